### design/xmlee_pkg.sv
// shared constants and a helper function for the xml entity escape/unescape block
`default_nettype none
package xmlee_pkg;

  typedef logic [7:0] byte_t;

  typedef enum logic {
    MODE_ESCAPE   = 1'b0,
    MODE_UNESCAPE = 1'b1
  } mode_t;

  localparam byte_t CH_AMP  = 8'h26;
  localparam byte_t CH_SEMI = 8'h3b;
  localparam byte_t CH_LT   = 8'h3c;
  localparam byte_t CH_GT   = 8'h3e;
  localparam byte_t CH_G    = 8'h67;
  localparam byte_t CH_L    = 8'h6c;
  localparam byte_t CH_T    = 8'h74;

  localparam int unsigned HeldDepth  = 3;
  localparam int unsigned BurstDepth = 4;

  // does byte b continue a held prefix of n bytes toward "&gt;" or "&lt;"
  function automatic logic prefix_extends(input logic [1:0] n, input byte_t b);
    logic r;
    begin
      case (n)
        2'd0:    r = (b == CH_AMP);
        2'd1:    r = (b == CH_G) || (b == CH_L);
        2'd2:    r = (b == CH_T);
        default: r = 1'b0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

### design/xml_entity_escape_unescape.sv
// top level: xml angle-bracket entity escaper and unescaper on byte streams
`default_nettype none
// Each accepted byte is expanded in the same cycle into a burst of zero to four
// output bytes, which then leave through a registered output stage at one byte
// per cycle while the sink is ready. A plain byte gives one output byte, '<' or
// '>' in escape mode gives four, and a held partial entity released in unescape
// mode gives up to four. The next item is taken in the cycle the last byte of
// the current burst moves to the output register, so the output register may
// still wait on the sink while new input is accepted.
// m_tlast marks the final byte of the string, m_tuser the final byte caused by
// one input item. Writing the mode register drops any held prefix; write it
// only while the block is idle.
module xml_entity_escape_unescape (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_tvalid,
  output logic              s_tready,
  input  wire  [7:0]        s_tdata,   // [7:0] in_byte
  input  wire               s_tlast,   // in_last
  output logic              m_tvalid,
  input  wire               m_tready,
  output logic [7:0]        m_tdata,   // [7:0] out_byte
  output logic              m_tlast,   // string_end
  output logic              m_tuser,   // [0] run_last
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire               cfg_data
);
  import xmlee_pkg::*;

  mode_t       mode;
  byte_t       held_bytes [HeldDepth];
  logic [1:0]  held_count;
  logic [1:0]  held_count_next;
  logic        held_wr;
  logic [1:0]  held_wr_idx;

  byte_t       burst [BurstDepth];
  logic [2:0]  burst_rem;
  logic [1:0]  burst_idx;
  logic        burst_last;

  byte_t       exp_bytes [BurstDepth];
  logic [2:0]  exp_cnt;
  byte_t       b;
  logic        in_acc;
  logic        mv;

  assign b         = s_tdata;
  assign cfg_ready = 1'b1;
  assign mv        = (burst_rem != 3'd0) && (!m_tvalid || m_tready);
  assign s_tready  = (burst_rem == 3'd0) || ((burst_rem == 3'd1) && mv);
  assign in_acc    = s_tvalid && s_tready;

  always_comb begin
    byte_t lst [BurstDepth];
    lst[0] = (held_count > 2'd0) ? held_bytes[0] : b;
    lst[1] = (held_count > 2'd1) ? held_bytes[1] : b;
    lst[2] = (held_count > 2'd2) ? held_bytes[2] : b;
    lst[3] = b;
    exp_bytes       = lst;
    exp_cnt         = 3'd0;
    held_count_next = held_count;
    held_wr         = 1'b0;
    held_wr_idx     = held_count;
    if (mode == MODE_ESCAPE) begin
      if ((b == CH_GT) || (b == CH_LT)) begin
        exp_bytes[0] = CH_AMP;
        exp_bytes[1] = (b == CH_GT) ? CH_G : CH_L;
        exp_bytes[2] = CH_T;
        exp_bytes[3] = CH_SEMI;
        exp_cnt      = 3'd4;
      end else begin
        exp_bytes[0] = b;
        exp_cnt      = 3'd1;
      end
    end else if ((held_count == 2'd3) && (b == CH_SEMI)) begin
      exp_bytes[0]    = (held_bytes[1] == CH_G) ? CH_GT : CH_LT;
      exp_cnt         = 3'd1;
      held_count_next = 2'd0;
    end else if ((held_count != 2'd3) && prefix_extends(held_count, b)) begin
      held_wr = 1'b1;
      if (s_tlast) begin
        exp_cnt         = {1'b0, held_count} + 3'd1;
        held_count_next = 2'd0;
      end else begin
        held_count_next = held_count + 2'd1;
      end
    end else if ((b == CH_AMP) && !s_tlast) begin
      // release the old prefix, start a new one with this ampersand
      exp_cnt         = {1'b0, held_count};
      held_wr         = 1'b1;
      held_wr_idx     = 2'd0;
      held_count_next = 2'd1;
    end else begin
      exp_cnt         = {1'b0, held_count} + 3'd1;
      held_count_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_ESCAPE;
      held_count <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      mode       <= mode_t'(cfg_data);
      held_count <= 2'd0;
    end else if (in_acc) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && held_wr) begin
      held_bytes[held_wr_idx] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_rem <= 3'd0;
      burst_idx <= 2'd0;
    end else if (in_acc) begin
      burst_rem <= exp_cnt;
      burst_idx <= 2'd0;
    end else if (mv) begin
      burst_rem <= burst_rem - 3'd1;
      burst_idx <= burst_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      burst      <= exp_bytes;
      burst_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (mv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv) begin
      m_tdata <= burst[burst_idx];
      m_tuser <= (burst_rem == 3'd1);
      m_tlast <= (burst_rem == 3'd1) && burst_last;
    end
  end

`ifndef SYNTHESIS
  a_burst_bound: assert property (@(posedge clk) disable iff (rst)
    burst_rem <= 3'd4)
    else $error("burst count out of range");

  a_escape_no_held: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_ESCAPE) |-> (held_count == 2'd0))
    else $error("held bytes present in escape mode");

  a_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("string end without run end");

  a_last_has_output: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> (burst_rem != 3'd0))
    else $error("final item produced no output");
`endif

endmodule
`default_nettype wire

### tb/testbench.sv
// testbench for the xml entity escape/unescape block: directed, pressure and random tests
module testbench;
  import xmlee_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseItems   = 44;

  typedef struct packed {
    byte_t data;
    logic  run_last;
    logic  string_end;
  } text_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  text_result_t expected_text[$];
  mode_t        cur_mode = MODE_ESCAPE;
  byte_t        held_prefix[3];
  int unsigned  held_count = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  sink_hold = 0;
  int unsigned  items_sent = 0;
  bit           steady_flow = 1'b0;

  xml_entity_escape_unescape dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // expected bytes caused by one accepted text byte
  function automatic void predict_conversion(input byte_t b, input logic last);
    byte_t        burst[4];
    int           n;
    logic         grows;
    text_result_t r;
    n = 0;
    case (held_count)
      0:       grows = (b == CH_AMP);
      1:       grows = (b == CH_G) || (b == CH_L);
      2:       grows = (b == CH_T);
      default: grows = 1'b0;
    endcase
    if (cur_mode == MODE_ESCAPE) begin
      if (b == CH_GT || b == CH_LT) begin
        burst[0] = CH_AMP;
        burst[1] = (b == CH_GT) ? CH_G : CH_L;
        burst[2] = CH_T;
        burst[3] = CH_SEMI;
        n = 4;
      end else begin
        burst[0] = b;
        n = 1;
      end
    end else if (held_count == 3 && b == CH_SEMI) begin
      burst[0] = (held_prefix[1] == CH_G) ? CH_GT : CH_LT;
      n = 1;
      held_count = 0;
    end else if (grows) begin
      held_prefix[held_count] = b;
      held_count++;
      if (last) begin
        for (int i = 0; i < held_count; i++) begin
          burst[n] = held_prefix[i];
          n++;
        end
        held_count = 0;
      end
    end else begin
      for (int i = 0; i < held_count; i++) begin
        burst[n] = held_prefix[i];
        n++;
      end
      held_count = 0;
      if (b == CH_AMP && !last) begin
        held_prefix[0] = b;
        held_count = 1;
      end else begin
        burst[n] = b;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      r.data       = burst[i];
      r.run_last   = (i == n - 1);
      r.string_end = last && (i == n - 1);
      expected_text.insert(expected_text.size(), r);
    end
  endfunction

  task automatic send_text_byte(input byte_t b, input logic last);
    if (!steady_flow && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    predict_conversion(b, last);
    items_sent++;
  endtask

  task automatic send_string(input string text, input bit last_at_end);
    for (int i = 0; i < text.len(); i++)
      send_text_byte(byte_t'(text[i]), last_at_end && (i == text.len() - 1));
  endtask

  task automatic wait_for_drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_mode   = m;
    held_count = 0;
  endtask

  function automatic byte_t pick_text_byte();
    byte_t b;
    case ($urandom_range(0, 9))
      0:       b = CH_AMP;
      1:       b = CH_LT;
      2:       b = CH_GT;
      3:       b = CH_SEMI;
      4:       b = ($urandom_range(0, 1) != 0) ? CH_G : CH_L;
      5:       b = CH_T;
      default: b = byte_t'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  function automatic logic pick_last();
    return ($urandom_range(0, 11) == 0);
  endfunction

  // mostly well formed entities and prefixes, the rest noise
  task automatic send_unescape_segment;
    int    len;
    byte_t second;
    second = ($urandom_range(0, 1) != 0) ? CH_G : CH_L;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        send_text_byte(CH_AMP, 1'b0);
        send_text_byte(second, 1'b0);
        send_text_byte(CH_T, 1'b0);
        send_text_byte(CH_SEMI, pick_last());
      end
      5, 6: begin
        len = $urandom_range(1, 3);
        send_text_byte(CH_AMP, len == 1 && pick_last());
        if (len > 1) send_text_byte(second, len == 2 && pick_last());
        if (len > 2) send_text_byte(CH_T, pick_last());
        send_text_byte(pick_text_byte(), pick_last());
      end
      default: begin
        repeat ($urandom_range(1, 4)) send_text_byte(pick_text_byte(), pick_last());
      end
    endcase
  endtask

  task automatic test_escape_directed;
    write_mode(MODE_ESCAPE);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hff, 1'b0);
    send_text_byte(CH_LT, 1'b0);
    send_text_byte(CH_GT, 1'b0);
    send_text_byte(CH_AMP, 1'b0);
    send_text_byte(CH_LT, 1'b1);
  endtask

  task automatic test_unescape_directed;
    write_mode(MODE_UNESCAPE);
    send_string("&gt;", 1'b0);
    // ampersand after a partial match restarts the prefix
    send_string("&l&gt;", 1'b0);
    send_string("&gx", 1'b0);
    send_string("&gtz", 1'b0);
    send_string("&lt", 1'b1);
    send_string("&", 1'b1);
  endtask

  task automatic test_mode_write_drops_prefix;
    write_mode(MODE_UNESCAPE);
    send_string("&g", 1'b0);
    write_mode(MODE_UNESCAPE);
    send_string("t;", 1'b1);
    send_string("&l", 1'b0);
    write_mode(MODE_ESCAPE);
    send_text_byte(8'h78, 1'b1);
  endtask

  task automatic test_backpressure;
    write_mode(MODE_ESCAPE);
    steady_flow = 1'b1;
    repeat (40) send_text_byte(pick_text_byte(), pick_last());
    steady_flow = 1'b0;
    sink_hold = 300;
    repeat (30) send_text_byte(($urandom_range(0, 3) != 0) ? CH_GT : pick_text_byte(), 1'b0);
    wait_for_drain();
    write_mode(MODE_UNESCAPE);
    sink_hold = 200;
    repeat (12) send_unescape_segment();
  endtask

  task automatic test_random_text;
    int unsigned phase_end;
    for (int phase = 0; phase < 7; phase++) begin
      write_mode((phase % 2 != 0) ? MODE_UNESCAPE : MODE_ESCAPE);
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        if (cur_mode == MODE_UNESCAPE) send_unescape_segment();
        else send_text_byte(pick_text_byte(), pick_last());
      end
    end
  endtask

  always @(posedge clk) begin
    if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      m_tready <= steady_flow || ($urandom_range(0, 99) >= 20);
    end
  end

  always @(posedge clk) begin : check_output
    text_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", m_tdata));
      end else begin
        want = expected_text.pop_front();
        if (m_tdata !== want.data)
          report_mismatch($sformatf("byte %02h, want %02h", m_tdata, want.data));
        if (m_tuser !== want.run_last)
          report_mismatch($sformatf("run_last %b, want %b", m_tuser, want.run_last));
        if (m_tlast !== want.string_end)
          report_mismatch($sformatf("string_end %b, want %b", m_tlast, want.string_end));
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_escape_directed();
    test_unescape_directed();
    test_mode_write_drops_prefix();
    test_backpressure();
    test_random_text();
    wait_for_drain();
    repeat (20) @(posedge clk);
    if (expected_text.size() != 0) report_mismatch("expected bytes never arrived");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
design/xmlee_pkg.sv
design/xml_entity_escape_unescape.sv
tb/testbench.sv
